### hdl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/sti_pkg.sv
// Shared types and constants for the sorted key table.
package sti_pkg;

	localparam int CAPACITY_DEF = 128;
	localparam int KEY_W        = 32;
	localparam int STATUS_W     = 2;
	localparam int POS_W        = 8;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_FIND   = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		STAT_INSERTED  = 2'd0,
		STAT_FOUND     = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    load_item;
		logic    probe_rd;
		logic    probe_step;
		logic    shift_rd;
		logic    shift_wr;
		logic    key_wr;
		logic    res_en;
		status_t res_code;
		logic    load_out;
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_find;
		logic is_full;
		logic range_open;
		logic probe_eq;
		logic probe_right;
		logic shift_more;
	} dp_stat_t;

endpackage

### hdl/sorted_table_insert_search.sv
// Find: probes until a hit or an empty range; P probes <= ceil(log2(count+1)), 8 at 128.
// Insert: a search, then a shift of the S keys above the new slot, each read then written; a full table skips both.
// One transaction at a time: the next is taken in the cycle the result appears.
// A result waits in the output register while the next runs; a stall there holds the finish.
// Reset clears the key count, the sequencer state and the output valid; the key store holds no reset value.
// No clearing pass: entries at or above the count are never read.

module sorted_table_insert_search #(
	parameter int CAPACITY = sti_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             command,
	input  logic signed [sti_pkg::KEY_W-1:0] key,
	// output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [sti_pkg::STATUS_W-1:0]     status,
	output logic [sti_pkg::POS_W-1:0]        position,
	output logic [sti_pkg::POS_W-1:0]        entry_count
);

	// command/status between the sequencer and the datapath
	sti_pkg::ctrl_cmd_t cmd;
	sti_pkg::dp_stat_t  stat;

	// Sequencer: each search probe is a read state then a compare state;
	// each key moved in the insert shift is a read below then a write above.
	sti_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Datapath: key store, bounds lo/hx, shift pointer, output register.
	// Insert uses an upper-bound search so equal keys stay in arrival order.
	sti_datapath #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.command     (command),
		.key         (key),
		.status      (status),
		.position    (position),
		.entry_count (entry_count)
	);

endmodule

### hdl/sti_datapath.sv
// Key store, search bounds, shift pointer and result registers.
`include "assert_macros.svh"

module sti_datapath #(
	parameter int CAPACITY = sti_pkg::CAPACITY_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sti_pkg::ctrl_cmd_t            cmd,
	output sti_pkg::dp_stat_t             stat,
	input  logic                          command,
	input  logic signed [sti_pkg::KEY_W-1:0] key,
	output logic [sti_pkg::STATUS_W-1:0]  status,
	output logic [sti_pkg::POS_W-1:0]     position,
	output logic [sti_pkg::POS_W-1:0]     entry_count
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	logic signed [sti_pkg::KEY_W-1:0] mem [CAPACITY];
	logic signed [sti_pkg::KEY_W-1:0] rdata_q;
	logic signed [sti_pkg::KEY_W-1:0] key_q;
	logic                             cmd_q;
	logic [CW-1:0]                    count_q;
	logic [CW-1:0]                    lo_q;
	logic [CW-1:0]                    hx_q;   // exclusive upper bound
	logic [AW-1:0]                    mid_q;
	logic [AW-1:0]                    ptr_q;
	logic [CW-1:0]                    res_pos_q;
	sti_pkg::status_t                 res_code_q;
	logic [sti_pkg::STATUS_W-1:0]     status_q;
	logic [sti_pkg::POS_W-1:0]        position_q;
	logic [sti_pkg::POS_W-1:0]        entry_count_q;

	logic [CW:0]   mid_sum;
	logic [AW-1:0] mid;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic signed [sti_pkg::KEY_W-1:0] wr_data;

	// floor((lo + hi) / 2) with hi = hx - 1; only used while lo < hx
	assign mid_sum = {1'b0, lo_q} + {1'b0, hx_q} - {{CW{1'b0}}, 1'b1};
	assign mid     = AW'(mid_sum[CW:1]);

	always_comb begin
		rd_en   = cmd.probe_rd | cmd.shift_rd;
		rd_addr = cmd.probe_rd ? mid : (ptr_q - AW'(1));
		wr_en   = cmd.shift_wr | cmd.key_wr;
		wr_addr = cmd.shift_wr ? ptr_q : AW'(lo_q);
		wr_data = cmd.shift_wr ? rdata_q : key_q;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.key_wr) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			cmd_q <= command;
			key_q <= key;
			lo_q  <= '0;
			hx_q  <= count_q;
			ptr_q <= AW'(count_q);
		end
		if (cmd.probe_rd) begin
			mid_q <= mid;
		end
		if (cmd.probe_step) begin
			if (stat.probe_right) begin
				lo_q <= CW'(mid_q) + CW'(1);
			end else begin
				hx_q <= CW'(mid_q);
			end
		end
		if (cmd.shift_wr) begin
			ptr_q <= ptr_q - AW'(1);
		end
		if (cmd.res_en) begin
			res_code_q <= cmd.res_code;
			case (cmd.res_code)
				sti_pkg::STAT_FOUND:    res_pos_q <= CW'(mid_q);
				sti_pkg::STAT_INSERTED: res_pos_q <= lo_q;
				default:                res_pos_q <= count_q;
			endcase
		end
		if (cmd.load_out) begin
			status_q      <= res_code_q;
			position_q    <= sti_pkg::POS_W'(res_pos_q);
			entry_count_q <= sti_pkg::POS_W'(count_q);
		end
	end

	always_comb begin
		stat.is_find     = (cmd_q == sti_pkg::CMD_FIND);
		stat.is_full     = (count_q == CW'(CAPACITY));
		stat.range_open  = (lo_q < hx_q);
		stat.probe_eq    = (rdata_q == key_q);
		stat.probe_right = stat.is_find ? (rdata_q < key_q) : (rdata_q <= key_q);
		stat.shift_more  = (CW'(ptr_q) > lo_q);
	end

	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = entry_count_q;

	`ASSERT_IMPL(a_wr_room, clk, arst_n, cmd.key_wr, count_q < CW'(CAPACITY), "insert into full table")
	`ASSERT_NEXT(a_cnt_inc, clk, arst_n, cmd.key_wr, count_q == $past(count_q) + CW'(1), "count not bumped")
	`ASSERT_IMPL(a_probe_in_range, clk, arst_n, cmd.probe_rd, CW'(mid) < count_q, "probe beyond stored keys")

endmodule

### hdl/sti_controller.sv
// Sequencer for search, shift and result hand-off.
`include "assert_macros.svh"

module sti_controller (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	output logic               out_valid,
	input  logic               out_stall,
	input  sti_pkg::dp_stat_t  stat,
	output sti_pkg::ctrl_cmd_t cmd
);

	sti_pkg::state_t state_q;
	sti_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != sti_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sti_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		cmd.res_code = sti_pkg::STAT_INSERTED;
		case (state_q)
			sti_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = sti_pkg::ST_SEARCH;
				end
			end
			sti_pkg::ST_SEARCH: begin
				if (!stat.is_find && stat.is_full) begin
					cmd.res_en   = 1'b1;
					cmd.res_code = sti_pkg::STAT_FULL;
					state_d      = sti_pkg::ST_DONE;
				end else if (stat.range_open) begin
					cmd.probe_rd = 1'b1;
					state_d      = sti_pkg::ST_CMP;
				end else if (stat.is_find) begin
					cmd.res_en   = 1'b1;
					cmd.res_code = sti_pkg::STAT_NOT_FOUND;
					state_d      = sti_pkg::ST_DONE;
				end else begin
					state_d = sti_pkg::ST_SH_RD;
				end
			end
			sti_pkg::ST_CMP: begin
				if (stat.is_find && stat.probe_eq) begin
					cmd.res_en   = 1'b1;
					cmd.res_code = sti_pkg::STAT_FOUND;
					state_d      = sti_pkg::ST_DONE;
				end else begin
					cmd.probe_step = 1'b1;
					state_d        = sti_pkg::ST_SEARCH;
				end
			end
			sti_pkg::ST_SH_RD: begin
				if (stat.shift_more) begin
					cmd.shift_rd = 1'b1;
					state_d      = sti_pkg::ST_SH_WR;
				end else begin
					cmd.key_wr   = 1'b1;
					cmd.res_en   = 1'b1;
					cmd.res_code = sti_pkg::STAT_INSERTED;
					state_d      = sti_pkg::ST_DONE;
				end
			end
			sti_pkg::ST_SH_WR: begin
				cmd.shift_wr = 1'b1;
				state_d      = sti_pkg::ST_SH_RD;
			end
			sti_pkg::ST_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = sti_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sti_pkg::ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_leave_idle, clk, arst_n, in_valid && !in_stall, state_q == sti_pkg::ST_SEARCH, "accepted transaction not started")
	`ASSERT_IMPL(a_no_clobber, clk, arst_n, cmd.load_out, !out_valid_q || !out_stall, "pending result overwritten")

endmodule

### test/sti_checker.sv
// Shadow sorted key table that predicts and checks every reply of the key table.
module sti_checker #(
	parameter int CAPACITY = sti_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic                             command,
	input  logic signed [sti_pkg::KEY_W-1:0] key,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [sti_pkg::STATUS_W-1:0]     status,
	input  logic [sti_pkg::POS_W-1:0]        position,
	input  logic [sti_pkg::POS_W-1:0]        entry_count,
	output int                               mismatch_count,
	output int                               replies_due
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		sti_pkg::status_t          status;
		logic [sti_pkg::POS_W-1:0] position;
		logic [sti_pkg::POS_W-1:0] entry_count;
	} reply_t;

	reply_t                           awaited_replies[$];
	logic signed [sti_pkg::KEY_W-1:0] shadow_keys[CAPACITY];
	int                               shadow_count = 0;
	int                               errors = 0;
	int                               due = 0;

	assign mismatch_count = errors;
	assign replies_due    = due;

	// ordered insert or binary search on the shadow table
	task automatic apply_to_shadow_table(input logic cmd,
			input logic signed [sti_pkg::KEY_W-1:0] k, output reply_t r);
		int   slot;
		int   lo;
		int   hi;
		int   mid;
		logic hit;
		hit = 1'b0;
		if (cmd == sti_pkg::CMD_INSERT) begin
			if (shadow_count >= CAPACITY) begin
				r.status = sti_pkg::STAT_FULL;
				slot = shadow_count;
			end else begin
				// equal keys stay in arrival order
				slot = 0;
				while (slot < shadow_count && shadow_keys[slot] <= k)
					slot++;
				for (int m = shadow_count; m > slot; m--)
					shadow_keys[m] = shadow_keys[m-1];
				shadow_keys[slot] = k;
				shadow_count++;
				r.status = sti_pkg::STAT_INSERTED;
			end
		end else begin
			lo   = 0;
			hi   = shadow_count - 1;
			slot = shadow_count;
			while (!hit && lo <= hi) begin
				mid = (lo + hi) / 2;
				if (shadow_keys[mid] == k) begin
					hit  = 1'b1;
					slot = mid;
				end else if (shadow_keys[mid] < k) begin
					lo = mid + 1;
				end else begin
					hi = mid - 1;
				end
			end
			if (hit)
				r.status = sti_pkg::STAT_FOUND;
			else
				r.status = sti_pkg::STAT_NOT_FOUND;
		end
		r.position    = slot[sti_pkg::POS_W-1:0];
		r.entry_count = shadow_count[sti_pkg::POS_W-1:0];
	endtask

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			shadow_count = 0;
			awaited_replies.delete();
			due = 0;
		end else begin
			// replies first: a reply never belongs to a transaction taken on the same edge
			if (out_valid && !out_stall) begin
				if (awaited_replies.size() == 0) begin
					$display("%0t ns: unexpected reply, expected none, got status %0d position %0d",
						$time, status, position);
					errors++;
				end else begin
					want = awaited_replies.pop_front();
					check_field("status", want.status, status);
					check_field("position", want.position, position);
					check_field("entry_count", want.entry_count, entry_count);
				end
			end
			if (in_valid && !in_stall) begin
				apply_to_shadow_table(command, key, want);
				awaited_replies.push_back(want);
			end
			due = awaited_replies.size();
		end
	end

endmodule

### test/tb_top.sv
// Top of the sorted key table testbench: clock, reset, stimulus, back-pressure and verdict.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [sti_pkg::KEY_W-1:0] KEY_MIN = {1'b1, {(sti_pkg::KEY_W-1){1'b0}}};
	localparam logic signed [sti_pkg::KEY_W-1:0] KEY_MAX = ~KEY_MIN;

	// Items per random phase; four phases plus the directed opening make about 1600.
	localparam int PHASE_ITEMS = 395;
	// Settle time, a little over the longest insert (127 keys held, new key lowest).
	localparam int SETTLE_CYCLES = 300;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             command = sti_pkg::CMD_INSERT;
	logic signed [sti_pkg::KEY_W-1:0] key = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [sti_pkg::STATUS_W-1:0]     status;
	logic [sti_pkg::POS_W-1:0]        position;
	logic [sti_pkg::POS_W-1:0]        entry_count;
	int                               mismatch_count;
	int                               replies_due;

	// gaps between input transactions and stalls on the reply side, switched per phase
	bit                               gaps_on = 1'b1;
	bit                               stalls_on = 1'b1;

	// every key sent for insertion, so that finds can aim at stored keys and their neighbours
	logic signed [sti_pkg::KEY_W-1:0] seen_keys[$];

	sorted_table_insert_search u_dut (.*);

	sti_checker u_checker (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Key mix: stored keys and their neighbours (hits and near misses), a narrow band around
	// zero for plenty of duplicates, the full 32-bit range, and values at both ends.
	function automatic logic signed [sti_pkg::KEY_W-1:0] pick_key();
		int                               pick;
		int                               off;
		logic signed [sti_pkg::KEY_W-1:0] k;
		pick = $urandom_range(0, 9);
		if (pick < 4 && seen_keys.size() > 0) begin
			k   = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
			off = $urandom_range(0, 3);
			if (off == 0)
				k--;
			else if (off == 3)
				k++;
		end else if (pick < 7) begin
			k = int'($urandom_range(0, 16)) - 8;
		end else if (pick < 9) begin
			k = $urandom;
		end else if ($urandom_range(0, 1)) begin
			k = KEY_MIN + $urandom_range(0, 2);
		end else begin
			k = KEY_MAX - $urandom_range(0, 2);
		end
		return k;
	endfunction

	// One input transaction. Valid is only lowered when a gap is drawn, so back-to-back
	// transactions keep valid high without a low-high pair in the same step.
	task automatic send_item(input logic cmd, input logic signed [sti_pkg::KEY_W-1:0] k);
		int gap;
		gap = gaps_on ? $urandom_range(0, 10) : 0;
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			// payload is free to wander while valid is low
			command  <= 1'($urandom_range(0, 1));
			key      <= $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		key      <= k;
		do @(posedge clk); while (in_stall);
		if (cmd == sti_pkg::CMD_INSERT)
			seen_keys.push_back(k);
	endtask

	// Sender holds off until every outstanding reply has been returned.
	task automatic wait_for_replies();
		@(negedge clk);
		in_valid <= 1'b0;
		while (replies_due != 0) @(negedge clk);
	endtask

	// Reply side: a fresh stall length per reply, then wait for the transaction to go through.
	initial begin
		int hold;
		wait (arst_n);
		forever begin
			@(negedge clk);
			hold = stalls_on ? $urandom_range(0, 10) : 0;
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	initial begin
		logic cmd;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// Directed opening.
		// Finds on the empty table: not found at position 0, no slot read.
		send_item(sti_pkg::CMD_FIND, '0);
		send_item(sti_pkg::CMD_FIND, KEY_MIN);
		// Extremes, signs and duplicates; the repeated zeros must land after the first one.
		send_item(sti_pkg::CMD_INSERT, '0);
		send_item(sti_pkg::CMD_INSERT, KEY_MAX);
		send_item(sti_pkg::CMD_INSERT, KEY_MIN);
		send_item(sti_pkg::CMD_INSERT, -1);
		send_item(sti_pkg::CMD_INSERT, 1);
		send_item(sti_pkg::CMD_INSERT, '0);
		send_item(sti_pkg::CMD_INSERT, '0);
		send_item(sti_pkg::CMD_INSERT, 32'sh5555_5555);
		send_item(sti_pkg::CMD_INSERT, 32'shAAAA_AAAA);
		// Hits at both ends and in the middle, the duplicate run, and misses in the gaps.
		send_item(sti_pkg::CMD_FIND, KEY_MAX);
		send_item(sti_pkg::CMD_FIND, KEY_MIN);
		send_item(sti_pkg::CMD_FIND, '0);
		send_item(sti_pkg::CMD_FIND, -1);
		send_item(sti_pkg::CMD_FIND, 1);
		send_item(sti_pkg::CMD_FIND, 32'sh5555_5555);
		send_item(sti_pkg::CMD_FIND, 32'shAAAA_AAAA);
		send_item(sti_pkg::CMD_FIND, 2);
		send_item(sti_pkg::CMD_FIND, KEY_MAX - 1);
		send_item(sti_pkg::CMD_FIND, -2);
		wait_for_replies();

		// Random phases. Roughly one insert in six fills the 128-entry table part way
		// through, so later phases also see inserts refused on a full table.
		for (int ph = 0; ph < 4; ph++) begin
			gaps_on   = (ph == 0 || ph == 2);
			stalls_on = (ph == 0 || ph == 3);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				cmd = ($urandom_range(0, 5) == 0) ? sti_pkg::CMD_INSERT : sti_pkg::CMD_FIND;
				send_item(cmd, pick_key());
			end
			wait_for_replies();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && replies_due == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// Watchdog, several times the slowest legal run.
	initial begin
		#40_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
